// ----- sv/multi_channel_i2c_angle_sensor_poller_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the multi-channel I2C angle sensor poller
// Clocked assertions that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_I2C_ANGLE_SENSOR_POLLER_TOP_MACROS_SVH
`define MULTI_CHANNEL_I2C_ANGLE_SENSOR_POLLER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define MCAP_ASSERT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcap assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define MCAP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcap assertion failed");
`else
`define MCAP_ASSERT(name, clk, rst_n, ante, cons)
`define MCAP_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/mcap_pkg.sv -----
// ----------------------------------------------------------------------------
// mcap_pkg
// Types, codes and constants shared by the angle sensor poller modules.
// ----------------------------------------------------------------------------
package mcap_pkg;

  // Number of bus lanes carried on the ports.
  localparam int NUM_LANES = 4;
  localparam int ANGLE_W   = 16;

  typedef logic [NUM_LANES-1:0] lane_mask_t;

  // Action codes of an input word.
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_STATUS = 2'd1;
  localparam logic [1:0] ACT_ANGLE  = 2'd2;

  // Configuration register indexes.
  localparam int          CFG_IDX_W           = 2;
  localparam int          CFG_DATA_W          = 7;
  localparam logic [1:0]  CFG_ACTIVE_CHANNELS = 2'd0;
  localparam logic [1:0]  CFG_DEVICE_ADDRESS  = 2'd1;
  localparam logic [2:0]  RST_ACTIVE_CHANNELS = 3'd4;
  localparam logic [6:0]  RST_DEVICE_ADDRESS  = 7'h36;

  // Sensor registers and status bits.
  localparam logic [7:0] REG_ANGLE    = 8'h0C;
  localparam logic [7:0] REG_STATUS   = 8'h0B;
  localparam logic [7:0] MAG_PRESENT  = 8'h20;
  localparam logic [7:0] MAG_STRONG   = 8'h10;
  localparam logic [7:0] MAG_WEAK     = 8'h08;

  // Magnet codes.
  localparam logic [1:0] MAG_NONE       = 2'd0;
  localparam logic [1:0] MAG_TOO_STRONG = 2'd1;
  localparam logic [1:0] MAG_TOO_WEAK   = 2'd2;
  localparam logic [1:0] MAG_NORMAL     = 2'd3;

  // Sequencer phases, one per bus half-period.
  typedef enum logic [5:0] {
    PH_IDLE       = 6'd0,
    PH_S1_SETUP   = 6'd1,
    PH_S1_SDA_LO  = 6'd2,
    PH_S1_SCL_LO  = 6'd3,
    PH_WA_DATA    = 6'd4,
    PH_WA_SCL_HI  = 6'd5,
    PH_WA_SCL_LO  = 6'd6,
    PH_WA_ACK_REL = 6'd7,
    PH_WA_ACK_HI  = 6'd8,
    PH_WA_ACK_SMP = 6'd9,
    PH_RG_DATA    = 6'd10,
    PH_RG_SCL_HI  = 6'd11,
    PH_RG_SCL_LO  = 6'd12,
    PH_RG_ACK_REL = 6'd13,
    PH_RG_ACK_HI  = 6'd14,
    PH_RG_ACK_SMP = 6'd15,
    PH_S2_SETUP   = 6'd16,
    PH_S2_SDA_LO  = 6'd17,
    PH_S2_SCL_LO  = 6'd18,
    PH_RA_DATA    = 6'd19,
    PH_RA_SCL_HI  = 6'd20,
    PH_RA_SCL_LO  = 6'd21,
    PH_RA_ACK_REL = 6'd22,
    PH_RA_ACK_HI  = 6'd23,
    PH_RA_ACK_SMP = 6'd24,
    PH_B1_SCL_HI  = 6'd25,
    PH_B1_SAMPLE  = 6'd26,
    PH_B1_ACK_DRV = 6'd27,
    PH_B1_ACK_HI  = 6'd28,
    PH_B1_ACK_LO  = 6'd29,
    PH_B2_SCL_HI  = 6'd30,
    PH_B2_SAMPLE  = 6'd31,
    PH_B2_NACK    = 6'd32,
    PH_B2_NACK_HI = 6'd33,
    PH_B2_NACK_LO = 6'd34,
    PH_P_LOW      = 6'd35,
    PH_P_SCL_HI   = 6'd36,
    PH_P_SDA_HI   = 6'd37
  } phase_e;

  // Completion event handed from the sequencer to the result store.
  typedef struct packed {
    logic       done;
    logic       read_kind;
    lane_mask_t act;
    lane_mask_t failed;
  } finish_t;

  // One result word.
  typedef struct packed {
    logic [3:0]         scl_level;
    logic [3:0]         sda_release;
    logic               busy_res;
    logic               done_res;
    logic [3:0]         online_mask;
    logic [7:0]         magnet_codes;
    logic [ANGLE_W-1:0] angle_ch0;
    logic [ANGLE_W-1:0] angle_ch1;
    logic [ANGLE_W-1:0] angle_ch2;
    logic [ANGLE_W-1:0] angle_ch3;
  } result_t;

  // Decode the sensor status byte into a magnet code.
  function automatic logic [1:0] magnet_decode(input logic [7:0] status);
    logic [1:0] code;
    if ((status & MAG_PRESENT) == 8'h00) begin
      code = MAG_NONE;
    end else if ((status & MAG_STRONG) != 8'h00) begin
      code = MAG_TOO_STRONG;
    end else if ((status & MAG_WEAK) != 8'h00) begin
      code = MAG_TOO_WEAK;
    end else begin
      code = MAG_NORMAL;
    end
    return code;
  endfunction

endpackage

// ----- sv/mcap_channels.sv -----
// ----------------------------------------------------------------------------
// mcap channel interfaces
// Valid/ready channels for tick words, result words and register writes.
// ----------------------------------------------------------------------------

// Tick word: action and sampled SDA levels.
interface mcap_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [3:0] sda_sampled;

  modport source (output valid, action, sda_sampled, input ready);
  modport sink (input valid, action, sda_sampled, output ready);
endinterface

// Result word: line drive, status and latched readings.
interface mcap_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  scl_level;
  logic [3:0]  sda_release;
  logic        busy_res;
  logic        done_res;
  logic [3:0]  online_mask;
  logic [7:0]  magnet_codes;
  logic [15:0] angle_ch0;
  logic [15:0] angle_ch1;
  logic [15:0] angle_ch2;
  logic [15:0] angle_ch3;

  modport source (output valid, scl_level, sda_release, busy_res, done_res, online_mask,
                  magnet_codes, angle_ch0, angle_ch1, angle_ch2, angle_ch3, input ready);
  modport sink (input valid, scl_level, sda_release, busy_res, done_res, online_mask,
                magnet_codes, angle_ch0, angle_ch1, angle_ch2, angle_ch3, output ready);
endinterface

// Register write: index and data.
interface mcap_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [6:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/mcap_seq.sv -----
// ----------------------------------------------------------------------------
// mcap_seq
// Bus sequencer: phase, bit counter, line levels, NACK flags and shifters.
// ----------------------------------------------------------------------------
`include "multi_channel_i2c_angle_sensor_poller_top_macros.svh"

module mcap_seq #(
  parameter int CHANNELS = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [1:0]                   action_i,
  input  logic [3:0]                   sda_i,
  input  mcap_pkg::lane_mask_t         act_i,
  input  logic [6:0]                   dev_addr_i,
  output logic [3:0]                   scl_o,
  output logic [3:0]                   sda_o,
  output logic                         busy_o,
  output mcap_pkg::finish_t            fin_o,
  output logic [mcap_pkg::ANGLE_W-1:0] shift_o [CHANNELS]
);
  import mcap_pkg::*;

  phase_e             phase_q, phase_d, phase_cur;
  logic [2:0]         bit_cnt_q, bit_cnt_d, bit_cnt_cur;
  logic               kind_q, kind_cur;
  lane_mask_t         failed_q, failed_d, failed_cur;
  lane_mask_t         scl_q, scl_d, sda_q, sda_d;
  logic [ANGLE_W-1:0] shift_q [CHANNELS];
  logic [ANGLE_W-1:0] shift_d [CHANNELS];
  logic [ANGLE_W-1:0] shift_cur [CHANNELS];
  logic               start;
  logic               cnt_last;
  lane_mask_t         drv;
  logic [7:0]         tx_byte;
  logic               tx_bit;
  logic               done;

  // A start request only counts when idle with at least one bus in use.
  assign start = (phase_q == PH_IDLE) && (act_i != '0) &&
                 ((action_i == ACT_STATUS) || (action_i == ACT_ANGLE));

  // State as seen by this tick, after a possible start.
  always_comb begin
    phase_cur   = start ? PH_S1_SETUP : phase_q;
    bit_cnt_cur = start ? 3'd0 : bit_cnt_q;
    kind_cur    = start ? (action_i == ACT_ANGLE) : kind_q;
    failed_cur  = start ? '0 : failed_q;
    for (int i = 0; i < CHANNELS; i++) begin
      shift_cur[i] = start ? '0 : shift_q[i];
    end
  end

  assign drv      = act_i & ~failed_cur;
  assign cnt_last = (bit_cnt_cur == 3'd7);

  // Byte on the wire for the current address or register phase, MSB first.
  always_comb begin
    unique case (phase_cur)
      PH_WA_DATA: tx_byte = {dev_addr_i, 1'b0};
      PH_RG_DATA: tx_byte = kind_cur ? REG_ANGLE : REG_STATUS;
      default:    tx_byte = {dev_addr_i, 1'b1};
    endcase
  end
  assign tx_bit = tx_byte[~bit_cnt_cur];

  // Next phase and bit counter.
  always_comb begin
    phase_d   = phase_cur;
    bit_cnt_d = bit_cnt_cur;
    unique case (phase_cur)
      PH_S1_SETUP:   phase_d = PH_S1_SDA_LO;
      PH_S1_SDA_LO:  phase_d = PH_S1_SCL_LO;
      PH_S1_SCL_LO:  phase_d = PH_WA_DATA;
      PH_WA_DATA:    phase_d = PH_WA_SCL_HI;
      PH_WA_SCL_HI:  phase_d = PH_WA_SCL_LO;
      PH_WA_SCL_LO: begin
        bit_cnt_d = bit_cnt_cur + 3'd1;
        phase_d   = cnt_last ? PH_WA_ACK_REL : PH_WA_DATA;
      end
      PH_WA_ACK_REL: phase_d = PH_WA_ACK_HI;
      PH_WA_ACK_HI:  phase_d = PH_WA_ACK_SMP;
      PH_WA_ACK_SMP: phase_d = PH_RG_DATA;
      PH_RG_DATA:    phase_d = PH_RG_SCL_HI;
      PH_RG_SCL_HI:  phase_d = PH_RG_SCL_LO;
      PH_RG_SCL_LO: begin
        bit_cnt_d = bit_cnt_cur + 3'd1;
        phase_d   = cnt_last ? PH_RG_ACK_REL : PH_RG_DATA;
      end
      PH_RG_ACK_REL: phase_d = PH_RG_ACK_HI;
      PH_RG_ACK_HI:  phase_d = PH_RG_ACK_SMP;
      PH_RG_ACK_SMP: phase_d = PH_S2_SETUP;
      PH_S2_SETUP:   phase_d = PH_S2_SDA_LO;
      PH_S2_SDA_LO:  phase_d = PH_S2_SCL_LO;
      PH_S2_SCL_LO:  phase_d = PH_RA_DATA;
      PH_RA_DATA:    phase_d = PH_RA_SCL_HI;
      PH_RA_SCL_HI:  phase_d = PH_RA_SCL_LO;
      PH_RA_SCL_LO: begin
        bit_cnt_d = bit_cnt_cur + 3'd1;
        phase_d   = cnt_last ? PH_RA_ACK_REL : PH_RA_DATA;
      end
      PH_RA_ACK_REL: phase_d = PH_RA_ACK_HI;
      PH_RA_ACK_HI:  phase_d = PH_RA_ACK_SMP;
      PH_RA_ACK_SMP: phase_d = PH_B1_SCL_HI;
      PH_B1_SCL_HI:  phase_d = PH_B1_SAMPLE;
      PH_B1_SAMPLE: begin
        bit_cnt_d = bit_cnt_cur + 3'd1;
        phase_d   = cnt_last ? PH_B1_ACK_DRV : PH_B1_SCL_HI;
      end
      PH_B1_ACK_DRV: phase_d = PH_B1_ACK_HI;
      PH_B1_ACK_HI:  phase_d = PH_B1_ACK_LO;
      PH_B1_ACK_LO:  phase_d = kind_cur ? PH_B2_SCL_HI : PH_P_LOW;
      PH_B2_SCL_HI:  phase_d = PH_B2_SAMPLE;
      PH_B2_SAMPLE: begin
        bit_cnt_d = bit_cnt_cur + 3'd1;
        phase_d   = cnt_last ? PH_B2_NACK : PH_B2_SCL_HI;
      end
      PH_B2_NACK:    phase_d = PH_B2_NACK_HI;
      PH_B2_NACK_HI: phase_d = PH_B2_NACK_LO;
      PH_B2_NACK_LO: phase_d = PH_P_LOW;
      PH_P_LOW:      phase_d = PH_P_SCL_HI;
      PH_P_SCL_HI:   phase_d = PH_P_SDA_HI;
      PH_P_SDA_HI: begin
        phase_d   = PH_IDLE;
        bit_cnt_d = 3'd0;
      end
      default:       phase_d = PH_IDLE;
    endcase
  end

  // Line drive, NACK capture and data shifting for the current phase.
  always_comb begin
    scl_d    = scl_q;
    sda_d    = sda_q;
    failed_d = failed_cur;
    done     = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      shift_d[i] = shift_cur[i];
    end
    unique case (phase_cur) inside
      PH_S1_SETUP, PH_S2_SETUP: begin
        sda_d = sda_q | drv;
        scl_d = scl_q | drv;
      end
      PH_S1_SDA_LO, PH_S2_SDA_LO: sda_d = sda_q & ~drv;
      PH_S1_SCL_LO, PH_S2_SCL_LO, PH_WA_SCL_LO, PH_RG_SCL_LO, PH_RA_SCL_LO,
      PH_B1_ACK_LO, PH_B2_NACK_LO: scl_d = scl_q & ~drv;
      PH_WA_DATA, PH_RG_DATA, PH_RA_DATA: sda_d = tx_bit ? (sda_q | drv) : (sda_q & ~drv);
      PH_WA_SCL_HI, PH_RG_SCL_HI, PH_RA_SCL_HI, PH_WA_ACK_HI, PH_RG_ACK_HI,
      PH_RA_ACK_HI, PH_B1_SCL_HI, PH_B2_SCL_HI, PH_B1_ACK_HI,
      PH_B2_NACK_HI: scl_d = scl_q | drv;
      PH_WA_ACK_REL, PH_RG_ACK_REL, PH_RA_ACK_REL: sda_d = sda_q | drv;
      PH_WA_ACK_SMP, PH_RG_ACK_SMP, PH_RA_ACK_SMP: begin
        failed_d = failed_cur | (drv & sda_i);
        scl_d    = scl_q & ~drv;
      end
      PH_B1_SAMPLE, PH_B2_SAMPLE: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (act_i[i]) begin
            shift_d[i] = {shift_cur[i][ANGLE_W-2:0], sda_i[i]};
          end
        end
        scl_d = scl_q & ~drv;
      end
      // The first data byte of an angle read is acknowledged by pulling SDA low.
      PH_B1_ACK_DRV: sda_d = (sda_q | act_i) & ~(kind_cur ? drv : '0);
      PH_B2_NACK:    sda_d = sda_q | act_i;
      PH_P_LOW: begin
        scl_d = scl_q & ~act_i;
        sda_d = sda_q & ~act_i;
      end
      PH_P_SCL_HI:   scl_d = scl_q | act_i;
      PH_P_SDA_HI: begin
        sda_d = sda_q | act_i;
        done  = 1'b1;
      end
      default: ;
    endcase
  end

  // State registers advance once per accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      bit_cnt_q <= 3'd0;
      kind_q    <= 1'b0;
      failed_q  <= '0;
      scl_q     <= '1;
      sda_q     <= '1;
      for (int i = 0; i < CHANNELS; i++) begin
        shift_q[i] <= '0;
      end
    end else if (step_i) begin
      phase_q   <= phase_d;
      bit_cnt_q <= bit_cnt_d;
      kind_q    <= kind_cur;
      failed_q  <= failed_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      for (int i = 0; i < CHANNELS; i++) begin
        shift_q[i] <= shift_d[i];
      end
    end
  end

  // Idle buses always show both lines released.
  assign scl_o  = scl_d | ~act_i;
  assign sda_o  = sda_d | ~act_i;
  assign busy_o = (phase_d != PH_IDLE);

  assign fin_o.done      = done;
  assign fin_o.read_kind = kind_cur;
  assign fin_o.act       = act_i;
  assign fin_o.failed    = failed_cur;
  assign shift_o         = shift_cur;

  // The STOP step always returns the sequencer to idle.
  `MCAP_ASSERT_NEXT(a_stop_to_idle, clk_i, rst_ni, step_i && done, phase_q == PH_IDLE)
  // The bit counter is back at zero whenever no transfer runs.
  `MCAP_ASSERT(a_idle_count_zero, clk_i, rst_ni, phase_q == PH_IDLE, bit_cnt_q == 3'd0)
  // Without an accepted tick the bus state does not move.
  `MCAP_ASSERT_NEXT(a_hold_without_tick, clk_i, rst_ni, !step_i,
                    $stable(phase_q) && $stable(failed_q) && $stable(scl_q))

endmodule

// ----- sv/mcap_store.sv -----
// ----------------------------------------------------------------------------
// mcap_store
// Latched online flags, magnet codes and angles, updated at each STOP.
// ----------------------------------------------------------------------------
module mcap_store #(
  parameter int CHANNELS = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  mcap_pkg::finish_t            fin_i,
  input  logic [mcap_pkg::ANGLE_W-1:0] shift_i [CHANNELS],
  output mcap_pkg::lane_mask_t         online_o,
  output logic [7:0]                   magnet_o,
  output logic [mcap_pkg::ANGLE_W-1:0] angle_o [CHANNELS]
);
  import mcap_pkg::*;

  lane_mask_t         online_q, online_d;
  logic [7:0]         magnet_q, magnet_d;
  logic [ANGLE_W-1:0] angle_q [CHANNELS];
  logic [ANGLE_W-1:0] angle_d [CHANNELS];
  logic               commit;

  assign commit = step_i && fin_i.done;

  // Update the results of every bus that took part; a failed bus reads angle zero.
  always_comb begin
    online_d = online_q;
    magnet_d = magnet_q;
    for (int i = 0; i < CHANNELS; i++) begin
      angle_d[i] = angle_q[i];
    end
    if (commit) begin
      online_d = (online_q & ~fin_i.act) | (fin_i.act & ~fin_i.failed);
      for (int i = 0; i < CHANNELS; i++) begin
        if (fin_i.act[i]) begin
          if (fin_i.read_kind) begin
            angle_d[i] = fin_i.failed[i] ? '0 : shift_i[i];
          end else begin
            magnet_d[2*i +: 2] = magnet_decode(shift_i[i][7:0]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      online_q <= '0;
      magnet_q <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        angle_q[i] <= '0;
      end
    end else begin
      online_q <= online_d;
      magnet_q <= magnet_d;
      for (int i = 0; i < CHANNELS; i++) begin
        angle_q[i] <= angle_d[i];
      end
    end
  end

  // The result word carries the values as they stand after this tick.
  assign online_o = online_d;
  assign magnet_o = magnet_d;
  assign angle_o  = angle_d;

endmodule

// ----- sv/mcap_out_stage.sv -----
// ----------------------------------------------------------------------------
// mcap_out_stage
// Result register between the sequencer and the output channel.
// ----------------------------------------------------------------------------
`include "multi_channel_i2c_angle_sensor_poller_top_macros.svh"

module mcap_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_valid_i,
  output logic              load_ready_o,
  input  mcap_pkg::result_t res_i,
  mcap_out_if.source        out_o
);
  import mcap_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;
  logic    load;

  // A new word may enter when the register is empty or is being emptied now.
  assign load_ready_o = !valid_q || out_o.ready;
  assign load         = load_valid_i && load_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.scl_level    = res_q.scl_level;
  assign out_o.sda_release  = res_q.sda_release;
  assign out_o.busy_res     = res_q.busy_res;
  assign out_o.done_res     = res_q.done_res;
  assign out_o.online_mask  = res_q.online_mask;
  assign out_o.magnet_codes = res_q.magnet_codes;
  assign out_o.angle_ch0    = res_q.angle_ch0;
  assign out_o.angle_ch1    = res_q.angle_ch1;
  assign out_o.angle_ch2    = res_q.angle_ch2;
  assign out_o.angle_ch3    = res_q.angle_ch3;

  // A loaded word is offered on the next cycle.
  `MCAP_ASSERT_NEXT(a_load_shows_valid, clk_i, rst_ni, load, valid_q)

endmodule

// ----- sv/multi_channel_i2c_angle_sensor_poller_top.sv -----
// ----------------------------------------------------------------------------
// multi_channel_i2c_angle_sensor_poller_top
// Lockstep I2C register reader for up to four sensor buses.
// ----------------------------------------------------------------------------
// Each word on in_i is one bus half-period tick carrying an action (tick,
// status read, angle read) and the SDA level sampled on every bus. Each tick
// returns exactly one word on out_o with the SCL and SDA drive for every bus,
// busy and done flags, online flags, magnet codes and the four angles.
// A status read takes 109 ticks from the start word to the done word, both
// included, an angle read 128; starts while busy are ignored.
// An accepted tick's result word is registered and offered in the next cycle,
// and a tick can be accepted every cycle while the receiver keeps up: the
// sequencer step is a single pass of logic between the phase registers and the result register.
// If the receiver stalls, the result register holds its word and in_i.ready
// drops until it is taken; no tick is lost or repeated.
// Register writes on cfg_i (index 0 active bus count, index 1 device
// address) are always ready and apply from the next tick.
// Reset releases every line, returns to idle, clears all latched results and
// loads four active buses with device address 0x36.
// ----------------------------------------------------------------------------
module multi_channel_i2c_angle_sensor_poller_top #(
  parameter int CHANNELS = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mcap_in_if.sink   in_i,
  mcap_out_if.source out_o,
  mcap_cfg_if.sink  cfg_i
);
  import mcap_pkg::*;

  localparam logic [2:0] CH_MAX = 3'(CHANNELS);

  logic [2:0]         active_q;
  logic [6:0]         dev_addr_q;
  logic [2:0]         active_n;
  lane_mask_t         act;
  logic               step;
  logic               load_ready;
  logic [3:0]         scl_lvl, sda_lvl;
  logic               busy;
  finish_t            fin;
  logic [ANGLE_W-1:0] shift [CHANNELS];
  lane_mask_t         online;
  logic [7:0]         magnet;
  logic [ANGLE_W-1:0] angle_nxt [CHANNELS];
  logic [ANGLE_W-1:0] angle_lane [NUM_LANES];
  result_t            res;

  // Register writes.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= RST_ACTIVE_CHANNELS;
      dev_addr_q <= RST_DEVICE_ADDRESS;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ACTIVE_CHANNELS: active_q   <= cfg_i.data[2:0];
        CFG_DEVICE_ADDRESS:  dev_addr_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Buses in use, counts above the built lanes clamp to the lane count.
  assign active_n = (active_q > CH_MAX) ? CH_MAX : active_q;
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      act[i] = (3'(i) < active_n);
    end
  end

  assign in_i.ready = load_ready;
  assign step       = in_i.valid && load_ready;

  mcap_seq #(
    .CHANNELS (CHANNELS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .action_i   (in_i.action),
    .sda_i      (in_i.sda_sampled),
    .act_i      (act),
    .dev_addr_i (dev_addr_q),
    .scl_o      (scl_lvl),
    .sda_o      (sda_lvl),
    .busy_o     (busy),
    .fin_o      (fin),
    .shift_o    (shift)
  );

  mcap_store #(
    .CHANNELS (CHANNELS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .fin_i    (fin),
    .shift_i  (shift),
    .online_o (online),
    .magnet_o (magnet),
    .angle_o  (angle_nxt)
  );

  // Lanes that are not built report angle zero.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    if (g < CHANNELS) begin : g_built
      assign angle_lane[g] = angle_nxt[g];
    end else begin : g_absent
      assign angle_lane[g] = '0;
    end
  end

  // Assemble the result word.
  always_comb begin
    res.scl_level    = scl_lvl;
    res.sda_release  = sda_lvl;
    res.busy_res     = busy;
    res.done_res     = fin.done;
    res.online_mask  = online;
    res.magnet_codes = magnet;
    res.angle_ch0    = angle_lane[0];
    res.angle_ch1    = angle_lane[1];
    res.angle_ch2    = angle_lane[2];
    res.angle_ch3    = angle_lane[3];
  end

  mcap_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (in_i.valid),
    .load_ready_o (load_ready),
    .res_i        (res),
    .out_o        (out_o)
  );

endmodule
